FILE: hdl/keyboard_scancode_decoder_defines.svh
// Assertion macros for the keyboard scan code decoder.
// Each check is clocked on clk and disabled while arst_n is low.
`ifndef KEYBOARD_SCANCODE_DECODER_DEFINES_SVH
`define KEYBOARD_SCANCODE_DECODER_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent
`define KSD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyboard scan code decoder check failed");

// Consequent must hold in the cycle after the antecedent
`define KSD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyboard scan code decoder check failed");

`else

`define KSD_ASSERT_SAME(label, ante, cons)

`define KSD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: hdl/ksd_pkg.sv
`default_nettype none

package ksd_pkg;

	// Scan code set 1 make codes with fixed meaning
	localparam logic [7:0] SC_LSHIFT    = 8'h2A;
	localparam logic [7:0] SC_RSHIFT    = 8'h36;
	localparam logic [7:0] SC_CAPS      = 8'h3A;
	localparam logic [7:0] SC_ENTER     = 8'h1C;
	localparam logic [7:0] SC_BACKSPACE = 8'h0E;
	localparam logic [7:0] SC_SPACE     = 8'h39;

	// Fixed characters
	localparam logic [8:0] CP_NONE      = 9'h000;
	localparam logic [8:0] CP_LF        = 9'h00A;
	localparam logic [8:0] CP_BS        = 9'h008;
	localparam logic [8:0] CP_SPACE     = 9'h020;

	// Layout codes
	localparam logic LAYOUT_US = 1'b0;
	localparam logic LAYOUT_TR = 1'b1;

	// Table geometry and character classes
	localparam int          TABLE_LEN    = 58;
	localparam logic [7:0]  CASE_BIT     = 8'h20;
	localparam logic [7:0]  CTRL_LIMIT   = 8'h20;
	localparam logic [7:0]  SPECIAL_LO   = 8'h01;
	localparam logic [7:0]  SPECIAL_HI   = 8'h06;
	localparam logic [7:0]  SPECIAL_UP   = 8'h10;
	localparam logic [8:0]  ASCII_LIMIT  = 9'h080;

	typedef logic [7:0] tbl_t [TABLE_LEN];

	// Modifier flags carried between the state register and the decoder
	typedef struct packed {
		logic shift_held;
		logic caps_active;
	} ksd_flags_t;

	localparam tbl_t US_PLAIN = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
		8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	localparam tbl_t US_SHIFTED = '{
		8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
		8'h28, 8'h29, 8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
		8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	// Turkish Q: 0x01..0x06 lowercase special letters, 0x11..0x16 uppercase
	localparam tbl_t TR_PLAIN = '{
		8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38,
		8'h39, 8'h30, 8'h2A, 8'h2D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72,
		8'h74, 8'h79, 8'h75, 8'h04, 8'h6F, 8'h70, 8'h01, 8'h02, 8'h0A, 8'h00,
		8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h03,
		8'h69, 8'h22, 8'h00, 8'h2C, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E,
		8'h6D, 8'h05, 8'h06, 8'h2E, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	localparam tbl_t TR_SHIFTED = '{
		8'h00, 8'h1B, 8'h21, 8'h27, 8'h23, 8'h2B, 8'h25, 8'h26, 8'h2F, 8'h28,
		8'h29, 8'h3D, 8'h3F, 8'h5F, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52,
		8'h54, 8'h59, 8'h55, 8'h14, 8'h4F, 8'h50, 8'h11, 8'h12, 8'h0A, 8'h00,
		8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h13,
		8'h49, 8'h28, 8'h00, 8'h3B, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E,
		8'h4D, 8'h15, 8'h16, 8'h3A, 8'h00, 8'h2A, 8'h00, 8'h20
	};

	// Map a Turkish special letter code to its code point; others give none
	function automatic logic [8:0] special_point(input logic [7:0] code);
		logic [8:0] cp;
		begin
			case (code)
				8'h01:   cp = 9'h11F;
				8'h02:   cp = 9'h0FC;
				8'h03:   cp = 9'h15F;
				8'h04:   cp = 9'h131;
				8'h05:   cp = 9'h0F6;
				8'h06:   cp = 9'h0E7;
				8'h11:   cp = 9'h11E;
				8'h12:   cp = 9'h0DC;
				8'h13:   cp = 9'h15E;
				8'h14:   cp = 9'h130;
				8'h15:   cp = 9'h0D6;
				8'h16:   cp = 9'h0C7;
				default: cp = CP_NONE;
			endcase
			return cp;
		end
	endfunction

	// Invert letter case under caps lock
	function automatic logic [7:0] apply_caps(input logic [7:0] c, input ksd_flags_t f);
		logic [7:0] r;
		begin
			r = c;
			if (f.caps_active && !f.shift_held && c >= 8'h61 && c <= 8'h7A) begin
				r = c - CASE_BIT;
			end else if (f.caps_active && f.shift_held && c >= 8'h41 && c <= 8'h5A) begin
				r = c + CASE_BIT;
			end
			return r;
		end
	endfunction

endpackage

`default_nettype wire

FILE: hdl/ksd_decode.sv
`default_nettype none

module ksd_decode (
	input  wire logic [7:0]         scan_code,
	input  wire logic               layout,
	input  wire ksd_pkg::ksd_flags_t flags,
	output ksd_pkg::ksd_flags_t     flags_nxt,
	output logic [8:0]              code_point,
	output logic [6:0]              ascii_char
);
	import ksd_pkg::*;

	logic [5:0] idx;
	logic [7:0] entry;

	assign idx = scan_code[5:0];

	// Decode one word and work out the next modifier flags
	always_comb begin
		flags_nxt  = flags;
		code_point = CP_NONE;
		entry      = '0;
		if (scan_code[7]) begin
			// release: only the shift keys matter
			if (scan_code[6:0] == SC_LSHIFT[6:0] || scan_code[6:0] == SC_RSHIFT[6:0]) begin
				flags_nxt.shift_held = 1'b0;
			end
		end else begin
			case (scan_code)
				SC_LSHIFT, SC_RSHIFT: flags_nxt.shift_held = 1'b1;
				SC_CAPS:              flags_nxt.caps_active = !flags.caps_active;
				SC_ENTER:             code_point = CP_LF;
				SC_BACKSPACE:         code_point = CP_BS;
				SC_SPACE:             code_point = CP_SPACE;
				default: begin
					if (scan_code < 8'(TABLE_LEN)) begin
						if (layout == LAYOUT_TR) begin
							entry = flags.shift_held ? TR_SHIFTED[idx] : TR_PLAIN[idx];
						end else begin
							entry = flags.shift_held ? US_SHIFTED[idx] : US_PLAIN[idx];
						end
						if (entry == 8'h00) begin
							code_point = CP_NONE;
						end else if (layout == LAYOUT_TR && entry < CTRL_LIMIT) begin
							// special letters: caps without shift picks the uppercase form
							if (flags.caps_active && !flags.shift_held &&
									entry >= SPECIAL_LO && entry <= SPECIAL_HI) begin
								code_point = special_point(entry ^ SPECIAL_UP);
							end else begin
								code_point = special_point(entry);
							end
						end else begin
							code_point = {1'b0, apply_caps(entry, flags)};
						end
					end
				end
			endcase
		end
	end

	// Drop anything outside plain ASCII
	assign ascii_char = (code_point < ASCII_LIMIT) ? code_point[6:0] : 7'h00;

endmodule

`default_nettype wire

FILE: hdl/keyboard_scancode_decoder.sv
`default_nettype none
// Keyboard scan code decoder: takes one scan code set 1 byte per word and
// returns one word with the Unicode code point of the typed character (0 for
// none) and its ASCII form (0 when the code point is 0x80 or above). Shift and
// caps lock flags live inside the block; the layout register picks US English
// (0) or Turkish Q (1) and is written through layout_we/layout_wdata; the user
// must write it only while the block is idle, and the block itself does not
// enforce this. One word is accepted every cycle while in_stall is low; a taken
// word goes into the input register, and a single table lookup between that
// register and the result register produces the result. A stalled output holds
// the result register and backs up into the input register.

`include "keyboard_scancode_decoder_defines.svh"

module keyboard_scancode_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       layout_we,
	input  wire logic       layout_wdata,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] scan_code,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [8:0]      code_point,
	output logic [6:0]      ascii_char
);
	import ksd_pkg::*;

	logic       layout_q;
	ksd_flags_t flags_q;
	ksd_flags_t flags_nxt;
	logic       valid_s1;
	logic [7:0] scan_code_s1;
	logic       out_valid_q;
	logic [8:0] code_point_q;
	logic [6:0] ascii_char_q;
	logic [8:0] dec_code_point;
	logic [6:0] dec_ascii_char;
	logic       in_accept;
	logic       advance;

	// Move the input word on when the result register is free or draining
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	ksd_decode u_decode (
		.scan_code  (scan_code_s1),
		.layout     (layout_q),
		.flags      (flags_q),
		.flags_nxt  (flags_nxt),
		.code_point (dec_code_point),
		.ascii_char (dec_ascii_char)
	);

	// Control: layout, modifier flags and valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q    <= LAYOUT_US;
			flags_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (layout_we) begin
				layout_q <= layout_wdata;
			end
			if (advance) begin
				flags_q <= flags_nxt;
			end
			if (in_accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: capture input word and decoded result
	always_ff @(posedge clk) begin
		if (in_accept) begin
			scan_code_s1 <= scan_code;
		end
		if (advance) begin
			code_point_q <= dec_code_point;
			ascii_char_q <= dec_ascii_char;
		end
	end

	assign out_valid  = out_valid_q;
	assign code_point = code_point_q;
	assign ascii_char = ascii_char_q;

	// A full pipe under stall keeps both words
	`KSD_ASSERT_NEXT(a_hold_full, valid_s1 && out_valid_q && out_stall, valid_s1 && out_valid_q)
	// Input stalls only when a word waits in the input register
	`KSD_ASSERT_SAME(a_stall_needs_word, in_stall, valid_s1)
	// A release byte never yields a character
	`KSD_ASSERT_NEXT(a_release_silent, advance && scan_code_s1[7], code_point_q == CP_NONE)
	// Caps lock make code flips the caps flag
	`KSD_ASSERT_NEXT(a_caps_toggle, advance && scan_code_s1 == SC_CAPS, flags_q.caps_active != $past(flags_q.caps_active))

endmodule

`default_nettype wire
